// ===== design/alpha_blend_blit_clipped_core_defines.svh =====
// ----------------------------------------------------------------------------
// Alpha blend blit core: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_BLIT_CLIPPED_CORE_DEFINES_SVH
`define ALPHA_BLEND_BLIT_CLIPPED_CORE_DEFINES_SVH

// Condition in this cycle requires the consequence in the same cycle.
`define ABBC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition in this cycle requires the consequence in the next cycle.
`define ABBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/abbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Alpha blend blit core: package
// Widths, register indexes, blend constants and the pipeline control type.
// ----------------------------------------------------------------------------
package abbc_pkg;

   // Field widths.
   localparam int CoordInW  = 12;
   localparam int CsrW      = 13;
   localparam int CoordOutW = 14;
   localparam int ChanW     = 8;
   localparam int ProdW     = 2 * ChanW;
   localparam int CsrIndexW = 3;

   // Configuration register indexes.
   localparam logic [CsrIndexW-1:0] CSR_ORIGIN_X      = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_ORIGIN_Y      = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_DEST_WIDTH    = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_DEST_HEIGHT   = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_BITMAP_HEIGHT = 3'd4;

   // Full-scale channel value.
   localparam logic [ChanW-1:0] CHAN_MAX = 8'hFF;

   // Rounding bias of 127 plus the one that the divide-by-255 identity
   // (x + 1 + ((x + 1) >> 8)) >> 8 needs.
   localparam logic [ProdW-1:0] ROUND_BIAS = 16'd128;

   // Load enables for the three pipeline stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } pipe_adv_type;

endpackage

// ===== design/abbc_blend_chan.sv =====
// ----------------------------------------------------------------------------
// Alpha blend blit core: one colour channel
// Three-stage blend of one channel: products, rounded sum, divide by 255.
// ----------------------------------------------------------------------------
module abbc_blend_chan
   import abbc_pkg::*;
(
   input  logic             clock,
   input  pipe_adv_type     adv,
   input  logic [ChanW-1:0] alpha,
   input  logic [ChanW-1:0] src_chan,
   input  logic [ChanW-1:0] dst_chan,
   output logic [ChanW-1:0] result
);

   logic [ChanW-1:0] inv_alpha;
   logic [ProdW-1:0] prod_dst_in, prod_dst_ff;
   logic [ProdW-1:0] prod_src_in, prod_src_ff;
   logic [ProdW-1:0] num_in, num_ff;
   logic [ProdW-1:0] quot_sum;
   logic [ChanW-1:0] quot_in, quot_ff;

   // Stage one: the two weighted products.
   assign inv_alpha   = CHAN_MAX - alpha;
   assign prod_dst_in = {{ChanW{1'b0}}, inv_alpha} * {{ChanW{1'b0}}, dst_chan};
   assign prod_src_in = {{ChanW{1'b0}}, alpha} * {{ChanW{1'b0}}, src_chan};

   // Stage two: sum with rounding bias; stays below 65536.
   assign num_in = prod_dst_ff + prod_src_ff + ROUND_BIAS;

   // Stage three: exact division by 255 through the shift-and-add identity.
   assign quot_sum = num_ff + {{ChanW{1'b0}}, num_ff[ProdW-1:ChanW]};
   assign quot_in  = quot_sum[ProdW-1:ChanW];

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         prod_dst_ff <= prod_dst_in;
         prod_src_ff <= prod_src_in;
      end
      if (adv.s2) begin
         num_ff <= num_in;
      end
      if (adv.s3) begin
         quot_ff <= quot_in;
      end
   end

   assign result = quot_ff;

endmodule

// ===== design/abbc_coord.sv =====
// ----------------------------------------------------------------------------
// Alpha blend blit core: coordinate mapping and clipping
// Maps the source column and row to destination coordinates over three
// stages and decides whether the point lies inside the destination.
// ----------------------------------------------------------------------------
module abbc_coord
   import abbc_pkg::*;
(
   input  logic                        clock,
   input  pipe_adv_type                adv,
   input  logic signed [CsrW-1:0]      origin_x,
   input  logic signed [CsrW-1:0]      origin_y,
   input  logic [CsrW-1:0]             dest_width,
   input  logic [CsrW-1:0]             dest_height,
   input  logic [CsrW-1:0]             bitmap_height,
   input  logic [CoordInW-1:0]         src_col,
   input  logic [CoordInW-1:0]         src_row,
   output logic signed [CoordOutW-1:0] dest_x,
   output logic signed [CoordOutW-1:0] dest_y,
   output logic                        inside_res
);

   // The row result needs one bit more than the output before wrapping.
   localparam int YW = CoordOutW + 1;

   logic [CoordOutW-1:0] x1_in, x1_ff, x2_ff, x3_ff;
   logic [YW-1:0]        ybase1_in, ybase1_ff;
   logic [CoordInW-1:0]  row1_ff;
   logic [YW-1:0]        y2_in, y2_ff;
   logic                 x_ok2_in, x_ok2_ff;
   logic                 y_ok;
   logic [CoordOutW-1:0] y3_in, y3_ff;
   logic                 inside3_in, inside3_ff;

   // Stage one: column offset and the flipped row base.
   assign x1_in     = {origin_x[CsrW-1], origin_x} + {2'b00, src_col};
   assign ybase1_in = {{(YW-CsrW){origin_y[CsrW-1]}}, origin_y}
                      + {{(YW-CsrW){1'b0}}, bitmap_height} - {{(YW-1){1'b0}}, 1'b1};

   // Stage two: subtract the row and test the column.
   assign y2_in    = ybase1_ff - {{(YW-CoordInW){1'b0}}, row1_ff};
   assign x_ok2_in = !x1_ff[CoordOutW-1] && (x1_ff[CsrW-1:0] < dest_width);

   // Stage three: test the row and wrap it to the output width.
   assign y_ok       = !y2_ff[YW-1] && (y2_ff[CoordOutW-1:0] < {1'b0, dest_height});
   assign inside3_in = x_ok2_ff && y_ok;
   assign y3_in      = y2_ff[CoordOutW-1:0];

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         x1_ff     <= x1_in;
         ybase1_ff <= ybase1_in;
         row1_ff   <= src_row;
      end
      if (adv.s2) begin
         x2_ff    <= x1_ff;
         y2_ff    <= y2_in;
         x_ok2_ff <= x_ok2_in;
      end
      if (adv.s3) begin
         x3_ff      <= x2_ff;
         y3_ff      <= y3_in;
         inside3_ff <= inside3_in;
      end
   end

   assign dest_x     = x3_ff;
   assign dest_y     = y3_ff;
   assign inside_res = inside3_ff;

endmodule

// ===== design/alpha_blend_blit_clipped_core.sv =====
// ----------------------------------------------------------------------------
// Alpha blend blit core: top level
// Blends one source ARGB pixel over a destination pixel and maps it to
// clipped destination coordinates, one word per clock when not stalled.
// ----------------------------------------------------------------------------
// The core takes a new word on every clock while the result side does not
// stall, and delivers one result word for each. Each word passes through the
// three register stages of the channel blend (products, rounded sum, divide
// by 255), which the coordinate path follows in step. A stalled stage holds
// its word while empty stages ahead of it keep filling, so the input stalls
// only once every stage holds a word. The configuration registers are read
// directly by the pipeline and should be written only while no word is in
// flight.
`include "alpha_blend_blit_clipped_core_defines.svh"

module alpha_blend_blit_clipped_core
   import abbc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // Input words
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [CoordInW-1:0]         req_src_col,
   input  logic [CoordInW-1:0]         req_src_row,
   input  logic [31:0]                 req_src_pixel,
   input  logic [31:0]                 req_dest_pixel,
   // Result words
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [CoordOutW-1:0] rsp_dest_x,
   output logic signed [CoordOutW-1:0] rsp_dest_y,
   output logic [23:0]                 rsp_blended,
   output logic                        rsp_inside_res,
   // Configuration writes
   input  logic                        csr_write,
   input  logic [CsrIndexW-1:0]        csr_index,
   input  logic [CsrW-1:0]             csr_data
);

   logic signed [CsrW-1:0] origin_x_ff, origin_y_ff;
   logic [CsrW-1:0]        dest_width_ff, dest_height_ff, bitmap_height_ff;
   logic                   v1_ff, v2_ff, v3_ff;
   logic                   ready1, ready2, ready3;
   pipe_adv_type           adv;
   logic [ChanW-1:0]       blend_chan [3];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         dest_width_ff    <= '0;
         dest_height_ff   <= '0;
         bitmap_height_ff <= {{(CsrW-1){1'b0}}, 1'b1};
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ORIGIN_X:      origin_x_ff      <= csr_data;
            CSR_ORIGIN_Y:      origin_y_ff      <= csr_data;
            CSR_DEST_WIDTH:    dest_width_ff    <= csr_data;
            CSR_DEST_HEIGHT:   dest_height_ff   <= csr_data;
            CSR_BITMAP_HEIGHT: bitmap_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage readiness: a stage loads when it is empty or its word moves on.
   assign ready3    = !v3_ff || !rsp_stall;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign adv.s1    = ready1;
   assign adv.s2    = ready2;
   assign adv.s3    = ready3;
   assign req_stall = !ready1;

   // Valid bits travelling with the words.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= req_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Coordinate mapping and clip test.
   abbc_coord u_coord (
      .clock         (clock),
      .adv           (adv),
      .origin_x      (origin_x_ff),
      .origin_y      (origin_y_ff),
      .dest_width    (dest_width_ff),
      .dest_height   (dest_height_ff),
      .bitmap_height (bitmap_height_ff),
      .src_col       (req_src_col),
      .src_row       (req_src_row),
      .dest_x        (rsp_dest_x),
      .dest_y        (rsp_dest_y),
      .inside_res    (rsp_inside_res)
   );

   // One blend lane for each of blue, green and red.
   for (genvar c = 0; c < 3; c++) begin : g_chan
      abbc_blend_chan u_blend (
         .clock    (clock),
         .adv      (adv),
         .alpha    (req_src_pixel[31:24]),
         .src_chan (req_src_pixel[c*ChanW +: ChanW]),
         .dst_chan (req_dest_pixel[c*ChanW +: ChanW]),
         .result   (blend_chan[c])
      );
   end

   assign rsp_valid   = v3_ff;
   assign rsp_blended = {blend_chan[2], blend_chan[1], blend_chan[0]};

   // Checks on the pipeline control.
   `ABBC_ASSERT_SAME(a_stall_only_when_full, clock, reset, !v1_ff, !req_stall, "input stalled")
   `ABBC_ASSERT_NEXT(a_stage2_moves_on, clock, reset, v2_ff && ready3, rsp_valid, "word lost")
   `ABBC_ASSERT_NEXT(a_stage1_held, clock, reset, v1_ff && !ready2, v1_ff, "held word dropped")

endmodule
